// ===== design/rpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpsf_pkg
// Shared constants, types and the CORDIC step table of the radar point
// spherical filter.
// ----------------------------------------------------------------------------
package rpsf_pkg;

    localparam int DEF_COORD_WIDTH  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int ID_W   = 32;
    localparam int STR_W  = 16;
    localparam int DIST_W = 16;
    localparam int LIM_W  = 15;
    localparam int BEAR_W = 15;
    localparam int ELEV_W = 14;

    localparam int ANG_TAB_LEN = 24;
    localparam int STEP_W      = $clog2(ANG_TAB_LEN);
    localparam int ANG_PRE_SH  = 8;
    localparam int ACC_W       = 24;
    localparam int ANG_W       = ACC_W - ANG_PRE_SH;
    localparam int ANG_QUARTER = 1474560;
    localparam int ANG_RND     = 1 << (ANG_PRE_SH - 1);

    localparam int BEAR_LIMIT = 11520;
    localparam int ELEV_LIMIT = 5760;
    localparam int LIM_RESET  = 5760;

    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEV = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AZIM = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_HROOT_GO,
        ST_HROOT_WAIT,
        ST_RROOT_GO,
        ST_ELEV_GO,
        ST_FIN_WAIT,
        ST_DECIDE
    } t_state;

    // atan(2^-i) in 1/16384 degree
    function automatic logic signed [ACC_W-1:0] step_angle(input logic [STEP_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = ACC_W'(737280);
            5'd1:    v = ACC_W'(435242);
            5'd2:    v = ACC_W'(229970);
            5'd3:    v = ACC_W'(116736);
            5'd4:    v = ACC_W'(58595);
            5'd5:    v = ACC_W'(29326);
            5'd6:    v = ACC_W'(14667);
            5'd7:    v = ACC_W'(7334);
            5'd8:    v = ACC_W'(3667);
            5'd9:    v = ACC_W'(1833);
            5'd10:   v = ACC_W'(917);
            5'd11:   v = ACC_W'(458);
            5'd12:   v = ACC_W'(229);
            5'd13:   v = ACC_W'(115);
            5'd14:   v = ACC_W'(57);
            5'd15:   v = ACC_W'(29);
            5'd16:   v = ACC_W'(14);
            5'd17:   v = ACC_W'(7);
            5'd18:   v = ACC_W'(4);
            5'd19:   v = ACC_W'(2);
            5'd20:   v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rpsf_in_if.sv =====
// ----------------------------------------------------------------------------
// rpsf_in_if
// Point input channel: valid/ready with one radar point per beat.
// ----------------------------------------------------------------------------
interface rpsf_in_if import rpsf_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_pos;
    logic signed [COORD_WIDTH-1:0] y_pos;
    logic signed [COORD_WIDTH-1:0] z_pos;
    logic        [STR_W-1:0]       strength;

    modport source (output valid, x_pos, y_pos, z_pos, strength, input ready);
    modport sink   (input valid, x_pos, y_pos, z_pos, strength, output ready);
endinterface

// ===== design/rpsf_out_if.sv =====
// ----------------------------------------------------------------------------
// rpsf_out_if
// Filtered point output channel: valid/ready with one spherical point per beat.
// ----------------------------------------------------------------------------
interface rpsf_out_if import rpsf_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic        [ID_W-1:0]        point_number;
    logic signed [COORD_WIDTH-1:0] x_out;
    logic signed [COORD_WIDTH-1:0] y_out;
    logic signed [COORD_WIDTH-1:0] z_out;
    logic        [DIST_W-1:0]      distance;
    logic signed [BEAR_W-1:0]      bearing_angle;
    logic signed [ELEV_W-1:0]      elevation_angle;
    logic        [STR_W-1:0]       strength_out;

    modport source (output valid, point_number, x_out, y_out, z_out, distance,
                    bearing_angle, elevation_angle, strength_out, input ready);
    modport sink   (input valid, point_number, x_out, y_out, z_out, distance,
                    bearing_angle, elevation_angle, strength_out, output ready);
endinterface

// ===== design/rpsf_isqrt.sv =====
// ----------------------------------------------------------------------------
// rpsf_isqrt
// Bit-serial integer square root, two operand bits per cycle, result rounded
// to nearest.
// ----------------------------------------------------------------------------
module rpsf_isqrt import rpsf_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2*COORD_WIDTH+1:0]   i_opnd,
    output logic                       o_busy,
    output logic [COORD_WIDTH:0]       o_root
);
    localparam int SW    = 2 * COORD_WIDTH + 2;
    localparam int NST   = SW / 2;
    localparam int RW    = COORD_WIDTH + 1;
    localparam int REM_W = COORD_WIDTH + 4;
    localparam int CNT_W = $clog2(NST + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_op;
    logic [REM_W-1:0] r_rem;
    logic [RW-1:0]    r_root;

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem2  = {r_rem[REM_W-3:0], r_op[SW-1 -: 2]};
    assign trial = REM_W'({r_root, 2'b01});
    assign take  = (rem2 >= trial);

    assign o_busy = (r_cnt != '0);
    assign o_root = (r_rem > REM_W'(r_root)) ? r_root + RW'(1) : r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NST);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_opnd;
            r_rem  <= '0;
            r_root <= '0;
        end else if (o_busy) begin
            r_op <= {r_op[SW-3:0], 2'b00};
            if (take) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== design/rpsf_cordic.sv =====
// ----------------------------------------------------------------------------
// rpsf_cordic
// Iterative vectoring CORDIC: atan2(y, x) in 1/64 degree, one micro-rotation
// per cycle after a quarter-turn pre-rotation for negative x.
// ----------------------------------------------------------------------------
module rpsf_cordic import rpsf_pkg::*; #(
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_WIDTH:0]  i_x,
    input  logic signed [COORD_WIDTH:0]  i_y,
    output logic                         o_busy,
    output logic signed [ANG_W-1:0]      o_angle
);
    localparam int OW = COORD_WIDTH + 1;
    localparam int CW = OW + ANG_PRE_SH + 2;

    logic                    r_busy;
    logic                    r_zero;
    logic [STEP_W-1:0]       r_step;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CW-1:0]    tx;
    logic signed [CW-1:0]    ty;
    logic signed [ACC_W-1:0] rnd;
    logic                    org;
    logic                    last;

    assign xs   = $signed({{(CW-OW-ANG_PRE_SH){i_x[OW-1]}}, i_x, {ANG_PRE_SH{1'b0}}});
    assign ys   = $signed({{(CW-OW-ANG_PRE_SH){i_y[OW-1]}}, i_y, {ANG_PRE_SH{1'b0}}});
    assign org  = (i_x == '0) && (i_y == '0);
    assign tx   = r_x >>> r_step;
    assign ty   = r_y >>> r_step;
    assign last = (r_step == STEP_W'(CORDIC_STEPS - 1));
    assign rnd  = r_acc + ACC_W'(ANG_RND);

    assign o_busy  = r_busy;
    assign o_angle = r_zero ? '0 : rnd[ACC_W-1 -: ANG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_zero <= 1'b1;
        end else if (i_start) begin
            r_busy <= !org;
            r_zero <= org;
        end else if (r_busy && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            if (xs < 0) begin
                if (ys >= 0) begin
                    r_x   <= ys;
                    r_y   <= -xs;
                    r_acc <= ACC_W'(ANG_QUARTER);
                end else begin
                    r_x   <= -ys;
                    r_y   <= xs;
                    r_acc <= -ACC_W'(ANG_QUARTER);
                end
            end else begin
                r_x   <= xs;
                r_y   <= ys;
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_y >= 0) begin
                r_x   <= r_x + ty;
                r_y   <= r_y - tx;
                r_acc <= r_acc + step_angle(r_step);
            end else begin
                r_x   <= r_x - ty;
                r_y   <= r_y + tx;
                r_acc <= r_acc - step_angle(r_step);
            end
        end
    end

endmodule

// ===== design/radar_point_spherical_filter.sv =====
// ----------------------------------------------------------------------------
// radar_point_spherical_filter
// Converts a Cartesian radar point to range, bearing and elevation and drops
// points whose elevation or bearing lies above its limit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     beat
//  i_pt     in   valid/ready   x_pos, y_pos, z_pos, strength
//  o_pt     out  valid/ready   point_number, x/y/z_out, distance, angles, strength_out
//  i_cfg_*  in   write enable  max_elevation (0), max_azimuth (1)
//
//  The two serial square roots and the CORDIC set the time that one point takes.
//  i_pt.ready is high only while idle; a result waits in the output register
//  and the next point may enter meanwhile.
//  Synchronous active-low reset clears the point counter and sets both limits.
// ----------------------------------------------------------------------------
module radar_point_spherical_filter import rpsf_pkg::*; #(
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpsf_in_if.sink              i_pt,
    rpsf_out_if.source           o_pt,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIM_W-1:0]     i_cfg_data
);
    localparam int W  = COORD_WIDTH;
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 1;
    localparam int XW = RW + DIST_W;

    localparam logic signed [ANG_W-1:0] BEAR_HI = ANG_W'(BEAR_LIMIT);
    localparam logic signed [ANG_W-1:0] ELEV_HI = ANG_W'(ELEV_LIMIT);

    t_state r_state;
    t_state n_state;

    logic [ID_W-1:0]        r_count;
    logic signed [LIM_W-1:0] r_max_elev;
    logic signed [LIM_W-1:0] r_max_azim;

    logic signed [W-1:0]    r_x;
    logic signed [W-1:0]    r_y;
    logic signed [W-1:0]    r_z;
    logic [STR_W-1:0]       r_str;
    logic [ID_W-1:0]        r_id;
    logic [2*W-1:0]         r_prod;
    logic [2*W:0]           r_hsq;
    logic [SW-1:0]          r_ssq;
    logic [W-1:0]           r_horiz;
    logic signed [ANG_W-1:0] r_bear;

    logic                    r_ov;
    logic                    n_ov;
    logic [ID_W-1:0]         r_o_id;
    logic signed [W-1:0]     r_o_x;
    logic signed [W-1:0]     r_o_y;
    logic signed [W-1:0]     r_o_z;
    logic [DIST_W-1:0]       r_o_dist;
    logic signed [BEAR_W-1:0] r_o_bear;
    logic signed [ELEV_W-1:0] r_o_elev;
    logic [STR_W-1:0]        r_o_str;

    logic                    in_rdy;
    logic                    accept;
    logic                    cd_start;
    logic                    cd_elev;
    logic                    sq_start;
    logic                    sq_sel_r;
    logic                    load_out;
    logic                    pass;

    logic signed [W-1:0]     m_val;
    logic [W-1:0]            m_mag;
    logic [2*W-1:0]          m_prod;

    logic [SW-1:0]           sq_opnd;
    logic                    sq_busy;
    logic [RW-1:0]           sq_root;
    logic signed [W:0]       cd_x;
    logic signed [W:0]       cd_y;
    logic                    cd_busy;
    logic signed [ANG_W-1:0] cd_angle;

    logic signed [ANG_W-1:0] bear_c;
    logic signed [ANG_W-1:0] elev_c;
    logic [XW-1:0]           rng_ext;
    logic [DIST_W-1:0]       dist_sat;

    rpsf_isqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_opnd  (sq_opnd),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    rpsf_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_x     (cd_x),
        .i_y     (cd_y),
        .o_busy  (cd_busy),
        .o_angle (cd_angle)
    );

    assign sq_opnd = sq_sel_r ? r_ssq : SW'(r_hsq);
    assign cd_x    = cd_elev ? $signed({1'b0, r_horiz}) : (W+1)'(r_x);
    assign cd_y    = cd_elev ? (W+1)'(r_z) : (W+1)'(r_y);

    always_comb begin
        case (r_state)
            ST_MUL_X: m_val = r_x;
            ST_MUL_Y: m_val = r_y;
            default:  m_val = r_z;
        endcase
        m_mag  = m_val[W-1] ? W'(-m_val) : W'(m_val);
        m_prod = m_mag * m_mag;
    end

    always_comb begin
        if (r_bear > BEAR_HI) begin
            bear_c = BEAR_HI;
        end else if (r_bear < -BEAR_HI) begin
            bear_c = -BEAR_HI;
        end else begin
            bear_c = r_bear;
        end
        if (cd_angle > ELEV_HI) begin
            elev_c = ELEV_HI;
        end else if (cd_angle < -ELEV_HI) begin
            elev_c = -ELEV_HI;
        end else begin
            elev_c = cd_angle;
        end
        pass     = (elev_c <= ANG_W'(r_max_elev)) && (bear_c <= ANG_W'(r_max_azim));
        rng_ext  = XW'(sq_root);
        dist_sat = (rng_ext > XW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : rng_ext[DIST_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        in_rdy   = 1'b0;
        cd_start = 1'b0;
        cd_elev  = 1'b0;
        sq_start = 1'b0;
        sq_sel_r = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_rdy = 1'b1;
                if (i_pt.valid) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                cd_start = 1'b1;
                n_state  = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                n_state = ST_MUL_Z;
            end
            ST_MUL_Z: begin
                n_state = ST_HROOT_GO;
            end
            ST_HROOT_GO: begin
                sq_start = 1'b1;
                n_state  = ST_HROOT_WAIT;
            end
            ST_HROOT_WAIT: begin
                if (!sq_busy) begin
                    n_state = ST_RROOT_GO;
                end
            end
            ST_RROOT_GO: begin
                sq_start = 1'b1;
                sq_sel_r = 1'b1;
                n_state  = ST_ELEV_GO;
            end
            ST_ELEV_GO: begin
                cd_elev = 1'b1;
                if (!cd_busy) begin
                    cd_start = 1'b1;
                    n_state  = ST_FIN_WAIT;
                end
            end
            ST_FIN_WAIT: begin
                if (!cd_busy && !sq_busy) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!pass) begin
                    n_state = ST_IDLE;
                end else if (!r_ov || o_pt.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept = in_rdy && i_pt.valid;
    assign n_ov   = load_out || (r_ov && !o_pt.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_ov       <= 1'b0;
            r_max_elev <= LIM_W'(LIM_RESET);
            r_max_azim <= LIM_W'(LIM_RESET);
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (accept) begin
                r_count <= r_count + ID_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_ELEV: r_max_elev <= i_cfg_data;
                    CFG_MAX_AZIM: r_max_azim <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_pt.x_pos;
            r_y   <= i_pt.y_pos;
            r_z   <= i_pt.z_pos;
            r_str <= i_pt.strength;
            r_id  <= r_count;
        end
        if (r_state == ST_MUL_X || r_state == ST_MUL_Y || r_state == ST_MUL_Z) begin
            r_prod <= m_prod;
        end
        if (r_state == ST_MUL_Y) begin
            r_hsq <= (2*W+1)'(r_prod);
        end
        if (r_state == ST_MUL_Z) begin
            r_hsq <= r_hsq + (2*W+1)'(r_prod);
        end
        if (r_state == ST_HROOT_GO) begin
            r_ssq <= SW'(r_hsq) + SW'(r_prod);
        end
        if (r_state == ST_HROOT_WAIT && !sq_busy) begin
            r_horiz <= sq_root[W-1:0];
        end
        if (r_state == ST_ELEV_GO && !cd_busy) begin
            r_bear <= cd_angle;
        end
        if (load_out) begin
            r_o_id   <= r_id;
            r_o_x    <= r_x;
            r_o_y    <= r_y;
            r_o_z    <= r_z;
            r_o_dist <= dist_sat;
            r_o_bear <= bear_c[BEAR_W-1:0];
            r_o_elev <= elev_c[ELEV_W-1:0];
            r_o_str  <= r_str;
        end
    end

    assign i_pt.ready           = in_rdy;
    assign o_pt.valid           = r_ov;
    assign o_pt.point_number    = r_o_id;
    assign o_pt.x_out           = r_o_x;
    assign o_pt.y_out           = r_o_y;
    assign o_pt.z_out           = r_o_z;
    assign o_pt.distance        = r_o_dist;
    assign o_pt.bearing_angle   = r_o_bear;
    assign o_pt.elevation_angle = r_o_elev;
    assign o_pt.strength_out    = r_o_str;

endmodule

// ===== test/radar_point_spherical_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_point_spherical_filter_checker
// Watches the point and result channels and the limit write port, predicts
// range, bearing and elevation of every accepted point with its own CORDIC
// and square-root model, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module radar_point_spherical_filter_checker import rpsf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpsf_in_if                   i_pt_mon,
    rpsf_out_if                  i_res_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIM_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic        [ID_W-1:0]   id;
        logic signed [15:0]       x;
        logic signed [15:0]       y;
        logic signed [15:0]       z;
        logic        [DIST_W-1:0] range_q;
        logic signed [BEAR_W-1:0] bear;
        logic signed [ELEV_W-1:0] elev;
        logic        [STR_W-1:0]  str;
    } t_spherical_point;

    localparam longint ATAN_STEP [24] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };
    localparam longint QUARTER_TURN = 1474560;

    t_spherical_point pending_points[$];
    logic [ID_W-1:0]  point_seq;
    longint           elev_limit;
    longint           azim_limit;

    function automatic longint unsigned root_nearest(longint unsigned s);
        longint unsigned rem, r, b;
        rem = s;
        r   = 0;
        b   = 64'h4000_0000_0000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (rem > r) r = r + 1;
        return r;
    endfunction

    function automatic longint vector_angle_deg64(longint y, longint x);
        longint xs, ys, nx, ny, t, acc;
        if (x == 0 && y == 0) return 0;
        xs  = x * 256;
        ys  = y * 256;
        acc = 0;
        if (xs < 0) begin
            t = xs;
            if (ys >= 0) begin
                xs  = ys;
                ys  = -t;
                acc = QUARTER_TURN;
            end else begin
                xs  = -ys;
                ys  = t;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < DEF_CORDIC_STEPS && i < 24; i++) begin
            if (ys >= 0) begin
                nx  = xs + (ys >>> i);
                ny  = ys - (xs >>> i);
                acc = acc + ATAN_STEP[i];
            end else begin
                nx  = xs - (ys >>> i);
                ny  = ys + (xs >>> i);
                acc = acc - ATAN_STEP[i];
            end
            xs = nx;
            ys = ny;
        end
        return (acc + 128) >>> 8;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // returns 1 when the point passes both limits
    function automatic bit predict_point(input logic signed [15:0] x, y, z,
                                         input logic [15:0] s,
                                         input logic [ID_W-1:0] id,
                                         output t_spherical_point p);
        longint hsq, range_v, horiz, bear, elev;
        hsq     = longint'(x) * longint'(x) + longint'(y) * longint'(y);
        range_v = longint'(root_nearest(hsq + longint'(z) * longint'(z)));
        horiz   = longint'(root_nearest(hsq));
        bear    = clamp_sym(vector_angle_deg64(longint'(y), longint'(x)), BEAR_LIMIT);
        elev    = clamp_sym(vector_angle_deg64(longint'(z), horiz), ELEV_LIMIT);
        if (range_v > DIST_MAX) range_v = DIST_MAX;
        p.id      = id;
        p.x       = x;
        p.y       = y;
        p.z       = z;
        p.range_q = DIST_W'(range_v);
        p.bear    = BEAR_W'(bear);
        p.elev    = ELEV_W'(elev);
        p.str     = s;
        return (elev <= elev_limit) && (bear <= azim_limit);
    endfunction

    task automatic report_field(string name, longint exp_v, longint act_v, inout bit bad);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_spherical_point exp_p;
        t_spherical_point new_p;
        bit               bad;
        if (!i_rst_n) begin
            point_seq    = '0;
            elev_limit   = LIM_RESET;
            azim_limit   = LIM_RESET;
            o_fail_count = 0;
            pending_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_ELEV: elev_limit = longint'($signed(i_cfg_data));
                    CFG_MAX_AZIM: azim_limit = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual point %0d",
                             $time, i_res_mon.point_number);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_p = pending_points.pop_front();
                    bad   = 1'b0;
                    report_field("point_number", exp_p.id, i_res_mon.point_number, bad);
                    report_field("x_out", exp_p.x, i_res_mon.x_out, bad);
                    report_field("y_out", exp_p.y, i_res_mon.y_out, bad);
                    report_field("z_out", exp_p.z, i_res_mon.z_out, bad);
                    report_field("distance", exp_p.range_q, i_res_mon.distance, bad);
                    report_field("bearing_angle", exp_p.bear, i_res_mon.bearing_angle, bad);
                    report_field("elevation_angle", exp_p.elev,
                                 i_res_mon.elevation_angle, bad);
                    report_field("strength_out", exp_p.str, i_res_mon.strength_out, bad);
                    if (bad) o_fail_count = o_fail_count + 1;
                end
            end
            if (i_pt_mon.valid && i_pt_mon.ready) begin
                if (predict_point(i_pt_mon.x_pos, i_pt_mon.y_pos, i_pt_mon.z_pos,
                                  i_pt_mon.strength, point_seq, new_p))
                    pending_points.push_back(new_p);
                point_seq = point_seq + 1'b1;
            end
        end
        o_pending = pending_points.size();
    end

endmodule

// ===== test/radar_point_spherical_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_point_spherical_filter_tb
// Drives radar points and limit writes into the spherical filter: a directed
// set of axis, origin and extreme points, then random phases under several
// limit settings and idle patterns; the checker module gives the verdict data.
// ----------------------------------------------------------------------------
module radar_point_spherical_filter_tb import rpsf_pkg::*; ();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
    localparam int PHASE_ITEMS  = 225;
    localparam int SETTLE_GAP   = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [LIM_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    rpsf_in_if  pt_in ();
    rpsf_out_if pt_out ();

    radar_point_spherical_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_in),
        .o_pt       (pt_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    radar_point_spherical_filter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt_mon     (pt_in),
        .i_res_mon    (pt_out),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        pt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #10000000;
        $display("radar_point_spherical_filter test failed");
        $finish;
    end

    task automatic send_point(input logic signed [15:0] x, y, z, input logic [15:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_in.valid    <= 1'b1;
        pt_in.x_pos    <= x;
        pt_in.y_pos    <= y;
        pt_in.z_pos    <= z;
        pt_in.strength <= s;
        @(posedge i_clk);
        while (!pt_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid, drain results, then hold while a filtered point may finish
    task automatic settle(input int gap);
        pt_in.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic write_limits(input int elev, input int azim);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_ELEV;
        cfg_data <= LIM_W'(elev);
        @(negedge i_clk);
        cfg_idx  <= CFG_MAX_AZIM;
        cfg_data <= LIM_W'(azim);
        @(negedge i_clk);
        cfg_idx  <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data <= LIM_W'($urandom);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return 16'($urandom);
        if (sel < 70) return 16'(int'($urandom_range(1023)) - 512);
        if (sel < 82) return 16'(0);
        if (sel < 92) begin
            case ($urandom_range(4))
                0: return 16'(32767);
                1: return 16'(-32768);
                2: return 16'(1);
                3: return 16'(-1);
                default: return 16'(0);
            endcase
        end
        return 16'(int'($urandom_range(15)) - 8);
    endfunction

    task automatic run_directed();
        send_point(16'(0), 16'(0), 16'(0), 16'h0000);
        send_point(16'(32767), 16'(32767), 16'(32767), 16'hFFFF);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768, 16'h0000);
        send_point(16'(32767), 16'(0), 16'(0), 16'h5A5A);
        send_point(-16'sd32768, 16'(0), 16'(0), 16'hA5A5);
        send_point(16'(0), 16'(32767), 16'(0), 16'h0001);
        send_point(16'(0), -16'sd32768, 16'(0), 16'h8000);
        send_point(16'(0), 16'(0), 16'(32767), 16'h7FFF);
        send_point(16'(0), 16'(0), -16'sd32768, 16'hFFFE);
        send_point(-16'sd1, -16'sd1, 16'(1), 16'h1234);
        send_point(16'(1), 16'(0), 16'(0), 16'h4321);
        send_point(-16'sd1, 16'(0), 16'(0), 16'hFFFF);
        send_point(16'(0), -16'sd1, 16'(0), 16'h0F0F);
        send_point(16'(100), 16'(100), 16'(0), 16'hF0F0);
        send_point(-16'sd100, -16'sd1, 16'(50), 16'h00FF);
        send_point(-16'sd100, 16'(1), -16'sd50, 16'hFF00);
        send_point(16'(0), 16'(200), 16'(32767), 16'h3C3C);
        send_point(16'(32767), -16'sd32768, 16'(0), 16'hC3C3);
    endtask

    initial begin
        int elev_set [8];
        int azim_set [8];
        elev_set = '{11520, -11520, 0, 16383, 0, -2880, 11520, -16384};
        azim_set = '{11520, -11520, 0, 16383, 0, 11520, -5760, -16384};
        elev_set[4] = int'($urandom_range(23040)) - 11520;
        azim_set[4] = int'($urandom_range(23040)) - 11520;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_MAX_ELEV;
        cfg_data       = '0;
        pt_in.valid    = 1'b0;
        pt_in.x_pos    = '0;
        pt_in.y_pos    = '0;
        pt_in.z_pos    = '0;
        pt_in.strength = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int p = 0; p < 8; p++) begin
            settle(SETTLE_GAP);
            write_limits(elev_set[p], azim_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (PHASE_ITEMS)
                send_point(pick_coord(), pick_coord(), pick_coord(), 16'($urandom));
        end

        settle(100);
        if (fail_count == 0 && pending == 0) begin
            $display("radar_point_spherical_filter test passed");
        end else begin
            $display("radar_point_spherical_filter test failed");
        end
        $finish;
    end

endmodule
